### src/aalr_pkg.sv
// Shared types and codes for the anti-aliased line rasterizer.
package aalr_pkg;

    // Input word kinds, carried on s_tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // latch endpoints, start gradient division
        logic div_step;  // one restoring-division iteration
        logic div_last;  // final iteration, write gradient
        logic step;      // compute next column pair, advance line state
        logic send_hi;   // output shows the upper pixel of the pair
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic line_active;
    } dp_status_t;

endpackage

### src/aalr_ctrl.sv
// Controller state machine for the anti-aliased line rasterizer.
module aalr_ctrl
    import aalr_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_command,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRACTION_BITS);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_DIVIDE  = 4'b0010,
        S_SEND_LO = 4'b0100,
        S_SEND_HI = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] div_count_reg, div_count_next;

    always_comb begin
        state_next     = state_reg;
        div_count_next = div_count_reg;
        cmd            = '0;
        s_tready       = (state_reg == S_IDLE);
        m_tvalid       = (state_reg == S_SEND_LO) || (state_reg == S_SEND_HI);
        cmd.send_hi    = (state_reg == S_SEND_HI);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_command == CMD_LOAD) begin
                        cmd.load       = 1'b1;
                        div_count_next = '0;
                        state_next     = S_DIVIDE;
                    end else if (s_command == CMD_STEP && status.line_active) begin
                        cmd.step   = 1'b1;
                        state_next = S_SEND_LO;
                    end
                end
            end
            S_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (div_count_reg == DIV_LAST) begin
                    cmd.div_last = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    div_count_next = div_count_reg + 1'b1;
                end
            end
            S_SEND_LO: begin
                if (m_tready) begin
                    state_next = S_SEND_HI;
                end
            end
            S_SEND_HI: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            div_count_reg <= '0;
        end else begin
            state_reg     <= state_next;
            div_count_reg <= div_count_next;
        end
    end

    // output words only follow a captured column
    a_valid_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.step))
        else $error("result word without a step capture");

    a_div_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVIDE) |-> (div_count_reg <= DIV_LAST))
        else $error("division counter overran");

endmodule

### src/aalr_datapath.sv
// Datapath of the anti-aliased line rasterizer: setup, divider, column stepping.
module aalr_datapath
    import aalr_pkg::*;
#(
    parameter int COORD_BITS    = 11,
    parameter int FRACTION_BITS = 16,
    parameter int COVERAGE_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [COORD_BITS-1:0]    x_start,
    input  logic [COORD_BITS-1:0]    y_start,
    input  logic [COORD_BITS-1:0]    x_end,
    input  logic [COORD_BITS-1:0]    y_end,
    output logic [COORD_BITS:0]      pixel_x,
    output logic [COORD_BITS:0]      pixel_y,
    output logic [COVERAGE_BITS-1:0] coverage,
    output logic                     last_pixel
);

    localparam int C      = COORD_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int COV    = COVERAGE_BITS;
    localparam int PIX_W  = C + 1;
    localparam int ICPT_W = C + F + 1;
    localparam int MAG_W  = F + 1;
    localparam int REM_W  = C + 1;
    localparam int PROD_W = F + COV + 1;
    localparam logic [COV-1:0]    CMAX = '1;
    localparam logic [PROD_W-1:0] HALF = {{(COV + 1){1'b0}}, 1'b1, {(F - 1){1'b0}}};

    typedef enum logic [1:0] {
        PH_FIRST    = 2'd0,
        PH_INTERIOR = 2'd1,
        PH_LAST     = 2'd2
    } phase_t;

    // control state (reset)
    logic   line_active_reg, line_active_next;
    phase_t phase_reg, phase_next;
    logic [MAG_W-1:0] grad_mag_reg, grad_mag_next;
    logic   grad_neg_reg, grad_neg_next;

    // payload state
    logic              steep_reg, steep_next;
    logic [C-1:0]      major_pos_reg, major_pos_next;
    logic [C-1:0]      major_end_reg, major_end_next;
    logic [ICPT_W-1:0] icpt_reg, icpt_next;
    logic [REM_W-1:0]  div_rem_reg, div_rem_next;
    logic [C-1:0]      div_den_reg, div_den_next;
    logic [MAG_W-1:0]  div_quo_reg, div_quo_next;
    logic              div_neg_reg, div_neg_next;
    logic [PIX_W-1:0]  lo_x_reg, lo_x_next, lo_y_reg, lo_y_next;
    logic [PIX_W-1:0]  hi_x_reg, hi_x_next, hi_y_reg, hi_y_next;
    logic [COV-1:0]    lo_cov_reg, lo_cov_next, hi_cov_reg, hi_cov_next;
    logic              last_reg, last_next;

    // setup
    logic [C-1:0] adx, ady, a0, b0, a1, b1, ma0, mb0, ma1, mb1, dmaj, dmin;
    logic         steep, swap, neg;

    always_comb begin
        adx   = (x_start > x_end) ? x_start - x_end : x_end - x_start;
        ady   = (y_start > y_end) ? y_start - y_end : y_end - y_start;
        steep = ady > adx;
        a0    = steep ? y_start : x_start;
        b0    = steep ? x_start : y_start;
        a1    = steep ? y_end : x_end;
        b1    = steep ? x_end : y_end;
        swap  = a0 > a1;
        ma0   = swap ? a1 : a0;
        mb0   = swap ? b1 : b0;
        ma1   = swap ? a0 : a1;
        mb1   = swap ? b0 : b1;
        dmaj  = ma1 - ma0;
        neg   = mb1 < mb0;
        dmin  = neg ? mb0 - mb1 : mb1 - mb0;
    end

    // divider iteration
    logic             div_cmp;
    logic [REM_W-1:0] div_kept;
    logic [MAG_W-1:0] quo_shift;

    always_comb begin
        div_cmp   = div_rem_reg >= {1'b0, div_den_reg};
        div_kept  = div_cmp ? div_rem_reg - {1'b0, div_den_reg} : div_rem_reg;
        quo_shift = {div_quo_reg[MAG_W-2:0], div_cmp};
    end

    // column coverage and coordinates
    logic [PIX_W-1:0]  minor, minor_hi, major_pix;
    logic [F-1:0]      frac;
    logic [PROD_W-1:0] prod;
    logic [COV:0]      up_raw;
    logic [COV-1:0]    up, lo;
    logic              end_col;
    logic [ICPT_W-1:0] icpt_adv;
    logic [C-1:0]      pos_inc;

    always_comb begin
        minor     = icpt_reg[ICPT_W-1:F];
        frac      = icpt_reg[F-1:0];
        // frac * CMAX as a shift and subtract, then round
        prod      = PROD_W'({frac, {COV{1'b0}}}) - PROD_W'(frac) + HALF;
        up_raw    = prod[PROD_W-1:F];
        up        = (up_raw > {1'b0, CMAX}) ? CMAX : up_raw[COV-1:0];
        lo        = CMAX - up;
        end_col   = (phase_reg != PH_INTERIOR);
        minor_hi  = minor + PIX_W'(1);
        major_pix = {1'b0, (phase_reg == PH_LAST) ? major_end_reg : major_pos_reg};
        icpt_adv  = grad_neg_reg ? icpt_reg - ICPT_W'(grad_mag_reg)
                                 : icpt_reg + ICPT_W'(grad_mag_reg);
        pos_inc   = major_pos_reg + C'(1);
    end

    always_comb begin
        line_active_next = line_active_reg;
        phase_next       = phase_reg;
        grad_mag_next    = grad_mag_reg;
        grad_neg_next    = grad_neg_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        icpt_next        = icpt_reg;
        div_rem_next     = div_rem_reg;
        div_den_next     = div_den_reg;
        div_quo_next     = div_quo_reg;
        div_neg_next     = div_neg_reg;
        lo_x_next        = lo_x_reg;
        lo_y_next        = lo_y_reg;
        hi_x_next        = hi_x_reg;
        hi_y_next        = hi_y_reg;
        lo_cov_next      = lo_cov_reg;
        hi_cov_next      = hi_cov_reg;
        last_next        = last_reg;

        if (cmd.load) begin
            steep_next       = steep;
            major_pos_next   = ma0;
            major_end_next   = ma1;
            icpt_next        = {1'b0, mb0, {F{1'b0}}};
            div_rem_next     = {1'b0, dmin};
            div_den_next     = dmaj;
            div_quo_next     = '0;
            div_neg_next     = neg;
            phase_next       = PH_FIRST;
            line_active_next = 1'b1;
        end

        if (cmd.div_step) begin
            div_rem_next = {div_kept[REM_W-2:0], 1'b0};
            div_quo_next = quo_shift;
            if (cmd.div_last) begin
                // zero-length major axis gives a flat gradient
                grad_mag_next = (div_den_reg == '0) ? '0 : quo_shift;
                grad_neg_next = div_neg_reg && (div_den_reg != '0) && (quo_shift != '0);
            end
        end

        if (cmd.step) begin
            lo_x_next   = steep_reg ? minor : major_pix;
            lo_y_next   = steep_reg ? major_pix : minor;
            hi_x_next   = steep_reg ? minor_hi : major_pix;
            hi_y_next   = steep_reg ? major_pix : minor_hi;
            lo_cov_next = end_col ? (lo >> 1) : lo;
            hi_cov_next = end_col ? (up >> 1) : up;
            last_next   = (phase_reg == PH_LAST);
            unique case (phase_reg)
                PH_FIRST: begin
                    icpt_next      = icpt_adv;
                    major_pos_next = pos_inc;
                    phase_next     = (major_end_reg > pos_inc && pos_inc != '0)
                                     ? PH_INTERIOR : PH_LAST;
                end
                PH_INTERIOR: begin
                    icpt_next      = icpt_adv;
                    major_pos_next = pos_inc;
                    // wrap of the column counter also ends the run
                    if (pos_inc >= major_end_reg || pos_inc == '0) begin
                        phase_next = PH_LAST;
                    end
                end
                PH_LAST: begin
                    line_active_next = 1'b0;
                    phase_next       = PH_FIRST;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            phase_reg       <= PH_FIRST;
            grad_mag_reg    <= '0;
            grad_neg_reg    <= 1'b0;
        end else begin
            line_active_reg <= line_active_next;
            phase_reg       <= phase_next;
            grad_mag_reg    <= grad_mag_next;
            grad_neg_reg    <= grad_neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        steep_reg     <= steep_next;
        major_pos_reg <= major_pos_next;
        major_end_reg <= major_end_next;
        icpt_reg      <= icpt_next;
        div_rem_reg   <= div_rem_next;
        div_den_reg   <= div_den_next;
        div_quo_reg   <= div_quo_next;
        div_neg_reg   <= div_neg_next;
        lo_x_reg      <= lo_x_next;
        lo_y_reg      <= lo_y_next;
        hi_x_reg      <= hi_x_next;
        hi_y_reg      <= hi_y_next;
        lo_cov_reg    <= lo_cov_next;
        hi_cov_reg    <= hi_cov_next;
        last_reg      <= last_next;
    end

    assign status.line_active = line_active_reg;
    assign pixel_x    = cmd.send_hi ? hi_x_reg : lo_x_reg;
    assign pixel_y    = cmd.send_hi ? hi_y_reg : lo_y_reg;
    assign coverage   = cmd.send_hi ? hi_cov_reg : lo_cov_reg;
    assign last_pixel = cmd.send_hi & last_reg;

    a_line_ends_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(line_active_reg) |-> ($past(phase_reg) == PH_LAST))
        else $error("line ended before its last column");

    a_interior_needs_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_INTERIOR) |-> line_active_reg)
        else $error("interior column with no line");

    a_gradient_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        grad_mag_reg <= {1'b1, {F{1'b0}}})
        else $error("gradient magnitude above one");

endmodule

### src/antialiased_line_rasterizer.sv
// Top level of the Wu anti-aliased line rasterizer.
// Load word: accepted while idle, then the restoring divider forms a FRACTION_BITS+1 bit gradient
//   (one quotient bit per cycle) before the next word is taken.
// Step word: captures the column pair, then two result words, one per cycle while m_tready
//   is high; each word is held until taken. A step with no line loaded is accepted and dropped.
// Reset (aresetn low, synchronous) returns the controller to idle with no line loaded.
module antialiased_line_rasterizer
    import aalr_pkg::*;
#(
    parameter int COORD_BITS    = 11,
    parameter int FRACTION_BITS = 16,
    parameter int COVERAGE_BITS = 8,
    localparam int IN_TDATA_W   = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W  = ((2 * (COORD_BITS + 1) + COVERAGE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // x_start, y_start, x_end, y_end, zero pad
    input  logic                   s_tuser,  // command: 0 load endpoints, 1 step a column
    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // pixel_x, pixel_y, coverage, zero pad
    output logic                   m_tlast   // last_pixel
);

    localparam int C = COORD_BITS;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic [C:0]               pixel_x, pixel_y;
    logic [COVERAGE_BITS-1:0] coverage;

    // Controller: idle / divide / two send states. Ready only while idle.
    aalr_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: endpoint ordering, gradient divider, intercept and coverage.
    // The column pair is held in registers while the two words drain.
    aalr_datapath #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .COVERAGE_BITS (COVERAGE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .x_start    (s_tdata[C-1:0]),
        .y_start    (s_tdata[2*C-1:C]),
        .x_end      (s_tdata[3*C-1:2*C]),
        .y_end      (s_tdata[4*C-1:3*C]),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .coverage   (coverage),
        .last_pixel (m_tlast)
    );

    // pack result fields, lowest first, zero filled to whole bytes
    assign m_tdata = OUT_TDATA_W'({coverage, pixel_y, pixel_x});

endmodule
